>>> sv/apqd_pkg.sv
// shared types, constants and helpers for the adaptive priority queue drainer
package apqd_pkg;

    // default sizing, handed to the top level parameters
    localparam int APQD_QUEUE_DEPTH = 64;
    localparam int APQD_HANDLE_BITS = 16;

    // fixed field widths of the ports
    localparam int NUM_QUEUES  = 3;
    localparam int HANDLE_W    = 16;
    localparam int PRIO_W      = 3;
    localparam int KIND_W      = 2;
    localparam int QIDX_W      = 2;
    localparam int OCC_W       = 8;
    localparam int THR_W       = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int QUOTA_W     = 3;

    typedef logic [QIDX_W-1:0]  qidx_t;
    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [QUOTA_W-1:0] quota_t;
    typedef logic [THR_W-1:0]   thr_t;

    // result kinds
    localparam kind_t KIND_ACCEPTED  = 2'd0;
    localparam kind_t KIND_DROPPED   = 2'd1;
    localparam kind_t KIND_FORWARDED = 2'd2;

    // queue numbers
    localparam qidx_t Q_HIGH   = 2'd0;
    localparam qidx_t Q_MEDIUM = 2'd1;
    localparam qidx_t Q_LOW    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_BUSY_THRESHOLD     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODERATE_THRESHOLD = 2'd1;

    localparam thr_t BUSY_THRESHOLD_RST     = 8'd30;
    localparam thr_t MODERATE_THRESHOLD_RST = 8'd10;

    // drain quotas per backlog level, high / medium / low queue
    localparam quota_t QUOTA_BUSY_HI = 3'd4;
    localparam quota_t QUOTA_BUSY_MD = 3'd3;
    localparam quota_t QUOTA_BUSY_LO = 3'd2;
    localparam quota_t QUOTA_MOD_HI  = 3'd2;
    localparam quota_t QUOTA_MOD_MD  = 3'd2;
    localparam quota_t QUOTA_MOD_LO  = 3'd1;
    localparam quota_t QUOTA_IDLE    = 3'd1;

    // controller to datapath
    typedef struct packed {
        logic capture;      // latch the incoming beat
        logic enq_do;       // perform the enqueue and load its result
        logic tick_start;   // sample occupancy and set quotas
        logic q_advance;    // move on to the next queue
        logic drain_issue;  // pop one handle from the current queue
        logic out_load;     // load the popped handle into the output register
    } apqd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mode_tick;    // captured beat is a service tick
        logic out_free;     // output register can take a result this cycle
        logic total_zero;   // all queues empty
        logic q_done;       // walked past the low queue
        logic q_can_drain;  // current queue has quota and data
        logic more_work;    // another pop is still due in this round
    } apqd_status_t;

    // priority minus one, clamped to the three queues
    function automatic qidx_t prio_to_queue(input logic [PRIO_W-1:0] prio);
        qidx_t q;
        if (prio <= 3'd1) begin
            q = Q_HIGH;
        end else if (prio >= 3'd3) begin
            q = Q_LOW;
        end else begin
            q = Q_MEDIUM;
        end
        return q;
    endfunction

endpackage

>>> sv/apqd_ctrl.sv
// controller state machine of the adaptive priority queue drainer
module apqd_ctrl import apqd_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  apqd_status_t status,
    output apqd_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_RD   = 4'b0100,
        ST_WAIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.mode_tick) begin
                    if (status.total_zero) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.tick_start = 1'b1;
                        state_next     = ST_RD;
                    end
                end else if (status.out_free) begin
                    cmd.enq_do = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RD: begin
                if (status.q_done) begin
                    state_next = ST_IDLE;
                end else if (status.q_can_drain) begin
                    cmd.drain_issue = 1'b1;
                    state_next      = ST_WAIT;
                end else begin
                    cmd.q_advance = 1'b1;
                end
            end
            ST_WAIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = status.more_work ? ST_RD : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.drain_issue |=> (state_reg == ST_WAIT))
        else $error("pop not followed by result wait");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.enq_do || cmd.out_load) |-> status.out_free)
        else $error("result loaded into a busy output register");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.drain_issue |-> status.q_can_drain)
        else $error("pop from a queue with no quota or data");

endmodule

>>> sv/apqd_datapath.sv
// queue storage, pointers, fill counts, thresholds and output register
module apqd_datapath import apqd_pkg::*; #(
    parameter int QUEUE_DEPTH = APQD_QUEUE_DEPTH,
    parameter int HANDLE_BITS = APQD_HANDLE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_mode,
    input  logic [PRIO_W-1:0]      s_priority_req,
    input  logic [HANDLE_W-1:0]    s_packet_handle,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [THR_W-1:0]       cfg_data,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic [KIND_W-1:0]      m_kind,
    output logic [QIDX_W-1:0]      m_queue_index,
    output logic [HANDLE_W-1:0]    m_packet_handle_res,
    output logic [OCC_W-1:0]       m_total_occupancy,
    output logic                   m_last,
    input  apqd_cmd_t              cmd,
    output apqd_status_t           status
);

    localparam int STORE_W = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int PW      = $clog2(QUEUE_DEPTH);
    localparam int FW      = $clog2(QUEUE_DEPTH + 1);
    localparam int TW      = $clog2(NUM_QUEUES * QUEUE_DEPTH + 1);
    localparam int AW      = $clog2(NUM_QUEUES * QUEUE_DEPTH);
    localparam int MEM_D   = NUM_QUEUES * QUEUE_DEPTH;

    // queue storage, three regions of QUEUE_DEPTH entries
    logic [STORE_W-1:0] queue_store_mem [MEM_D];
    logic [STORE_W-1:0] rd_data_reg;

    logic [PW-1:0] head_reg [NUM_QUEUES];
    logic [PW-1:0] tail_reg [NUM_QUEUES];
    logic [FW-1:0] fill_reg [NUM_QUEUES];
    quota_t        quota_reg [NUM_QUEUES];
    logic [TW-1:0] total_reg;
    thr_t          busy_reg;
    thr_t          moderate_reg;
    qidx_t         cur_q_reg;

    logic                mode_reg;
    qidx_t               qsel_reg;
    logic [STORE_W-1:0]  handle_reg;

    logic                m_valid_reg;
    kind_t               kind_reg;
    qidx_t               qidx_reg;
    logic [HANDLE_W-1:0] handle_res_reg;
    logic [OCC_W-1:0]    occ_reg;
    logic                last_reg;

    logic [PW-1:0] tail_sel;
    logic [PW-1:0] head_sel;
    logic [FW-1:0] fill_sel;
    logic          enq_full;
    logic          can_drain;
    logic          more_work;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          out_free;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [AW-1:0] q_addr(input qidx_t q, input logic [PW-1:0] p);
        logic [AW-1:0] a;
        case (q)
            Q_MEDIUM: a = AW'(QUEUE_DEPTH) + AW'(p);
            Q_LOW:    a = AW'(2 * QUEUE_DEPTH) + AW'(p);
            default:  a = AW'(p);
        endcase
        return a;
    endfunction

    // per-queue selection by the enqueue target and by the drain cursor
    always_comb begin
        tail_sel  = '0;
        fill_sel  = '0;
        head_sel  = '0;
        can_drain = 1'b0;
        more_work = 1'b0;
        for (int j = 0; j < NUM_QUEUES; j++) begin
            if (QIDX_W'(j) == qsel_reg) begin
                tail_sel = tail_reg[j];
                fill_sel = fill_reg[j];
            end
            if (QIDX_W'(j) == cur_q_reg) begin
                head_sel  = head_reg[j];
                can_drain = (quota_reg[j] != '0) && (fill_reg[j] != '0);
            end
            if ((QIDX_W'(j) >= cur_q_reg) && (quota_reg[j] != '0) && (fill_reg[j] != '0)) begin
                more_work = 1'b1;
            end
        end
    end

    assign enq_full = (fill_sel == FW'(QUEUE_DEPTH));
    assign wr_addr  = q_addr(qsel_reg, tail_sel);
    assign rd_addr  = q_addr(cur_q_reg, head_sel);
    assign out_free = !m_valid_reg || m_ready;

    assign status.mode_tick   = mode_reg;
    assign status.out_free    = out_free;
    assign status.total_zero  = (total_reg == '0);
    assign status.q_done      = (cur_q_reg > Q_LOW);
    assign status.q_can_drain = can_drain;
    assign status.more_work   = more_work;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NUM_QUEUES; j++) begin
                head_reg[j]  <= '0;
                tail_reg[j]  <= '0;
                fill_reg[j]  <= '0;
                quota_reg[j] <= '0;
            end
            total_reg    <= '0;
            cur_q_reg    <= Q_HIGH;
            busy_reg     <= BUSY_THRESHOLD_RST;
            moderate_reg <= MODERATE_THRESHOLD_RST;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_BUSY_THRESHOLD) begin
                    busy_reg <= cfg_data;
                end else if (cfg_index == CFG_MODERATE_THRESHOLD) begin
                    moderate_reg <= cfg_data;
                end
            end

            if (cmd.enq_do && !enq_full) begin
                for (int j = 0; j < NUM_QUEUES; j++) begin
                    if (QIDX_W'(j) == qsel_reg) begin
                        tail_reg[j] <= ptr_inc(tail_reg[j]);
                        fill_reg[j] <= fill_reg[j] + FW'(1);
                    end
                end
                total_reg <= total_reg + TW'(1);
            end

            if (cmd.tick_start) begin
                cur_q_reg <= Q_HIGH;
                if (32'(total_reg) > 32'(busy_reg)) begin
                    quota_reg[0] <= QUOTA_BUSY_HI;
                    quota_reg[1] <= QUOTA_BUSY_MD;
                    quota_reg[2] <= QUOTA_BUSY_LO;
                end else if (32'(total_reg) > 32'(moderate_reg)) begin
                    quota_reg[0] <= QUOTA_MOD_HI;
                    quota_reg[1] <= QUOTA_MOD_MD;
                    quota_reg[2] <= QUOTA_MOD_LO;
                end else begin
                    quota_reg[0] <= QUOTA_IDLE;
                    quota_reg[1] <= QUOTA_IDLE;
                    quota_reg[2] <= QUOTA_IDLE;
                end
            end

            if (cmd.q_advance) begin
                cur_q_reg <= cur_q_reg + QIDX_W'(1);
            end

            if (cmd.drain_issue) begin
                for (int j = 0; j < NUM_QUEUES; j++) begin
                    if (QIDX_W'(j) == cur_q_reg) begin
                        head_reg[j]  <= ptr_inc(head_reg[j]);
                        fill_reg[j]  <= fill_reg[j] - FW'(1);
                        quota_reg[j] <= quota_reg[j] - QUOTA_W'(1);
                    end
                end
                total_reg <= total_reg - TW'(1);
            end

            if (cmd.enq_do || cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // captured beat and result payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg   <= s_mode;
            qsel_reg   <= prio_to_queue(s_priority_req);
            handle_reg <= STORE_W'(s_packet_handle);
        end
        if (cmd.enq_do) begin
            kind_reg       <= enq_full ? KIND_DROPPED : KIND_ACCEPTED;
            qidx_reg       <= qsel_reg;
            handle_res_reg <= HANDLE_W'(handle_reg);
            occ_reg        <= enq_full ? OCC_W'(total_reg) : OCC_W'(total_reg + TW'(1));
            last_reg       <= 1'b1;
        end else if (cmd.out_load) begin
            kind_reg       <= KIND_FORWARDED;
            qidx_reg       <= cur_q_reg;
            handle_res_reg <= HANDLE_W'(rd_data_reg);
            occ_reg        <= OCC_W'(total_reg);
            last_reg       <= !more_work;
        end
    end

    // queue memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.enq_do && !enq_full) begin
            queue_store_mem[wr_addr] <= handle_reg;
        end
        if (cmd.drain_issue) begin
            rd_data_reg <= queue_store_mem[rd_addr];
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_kind              = kind_reg;
    assign m_queue_index       = qidx_reg;
    assign m_packet_handle_res = handle_res_reg;
    assign m_total_occupancy   = occ_reg;
    assign m_last              = last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg == TW'(fill_reg[0]) + TW'(fill_reg[1]) + TW'(fill_reg[2]))
        else $error("occupancy total out of step with fill counts");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg[0] <= FW'(QUEUE_DEPTH)) && (fill_reg[1] <= FW'(QUEUE_DEPTH))
            && (fill_reg[2] <= FW'(QUEUE_DEPTH)))
        else $error("fill count beyond queue depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.drain_issue |=> (total_reg == $past(total_reg) - TW'(1)))
        else $error("pop did not lower the occupancy");

endmodule

>>> sv/adaptive_priority_queue_drainer_unit.sv
// top level of the adaptive priority queue drainer: three handle queues with
// backlog-adaptive weighted round robin service
//
// Each input beat is either an enqueue (s_mode 0) or a service tick (s_mode 1).
// An enqueue puts the handle on queue priority-1, clamped to high/medium/low,
// and always gives exactly one result beat: accepted, or dropped if that queue
// already holds QUEUE_DEPTH handles. A tick samples the total occupancy once:
// above busy_threshold it pops up to 4/3/2 handles from high/medium/low, above
// moderate_threshold up to 2/2/1, otherwise 1/1/1, queues taken in that order,
// one forwarded result beat per handle, m_last on the final one. A tick with
// all queues empty gives no result. One item is worked on at a time: an
// enqueue is captured, then updates its queue and loads its result once the
// output register is free; a tick is captured and sets up its quotas, then
// steps past each queue with no quota or data left, and every pop reads the
// queue memory through a registered read port before the handle reaches the
// output register. Back-pressure on m_ready stalls on top of this. The queue
// memory is not cleared after reset; only written entries are ever read.
// Thresholds may be written only while the block is idle.
module adaptive_priority_queue_drainer_unit import apqd_pkg::*; #(
    parameter int QUEUE_DEPTH = APQD_QUEUE_DEPTH,
    parameter int HANDLE_BITS = APQD_HANDLE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // input beats
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_mode,
    input  logic [PRIO_W-1:0]      s_priority_req,
    input  logic [HANDLE_W-1:0]    s_packet_handle,

    // result beats
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [KIND_W-1:0]      m_kind,
    output logic [QIDX_W-1:0]      m_queue_index,
    output logic [HANDLE_W-1:0]    m_packet_handle_res,
    output logic [OCC_W-1:0]       m_total_occupancy,
    output logic                   m_last,

    // threshold writes, index 0 busy, index 1 moderate
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [THR_W-1:0]       cfg_data
);

    apqd_cmd_t    cmd;
    apqd_status_t status;

    // threshold registers always take a write
    assign cfg_ready = 1'b1;

    // sequencing: capture, enqueue, quota setup and the pop loop
    apqd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // storage, pointers, counters and the output register
    apqd_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_mode              (s_mode),
        .s_priority_req      (s_priority_req),
        .s_packet_handle     (s_packet_handle),
        .cfg_valid           (cfg_valid),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .m_ready             (m_ready),
        .m_valid             (m_valid),
        .m_kind              (m_kind),
        .m_queue_index       (m_queue_index),
        .m_packet_handle_res (m_packet_handle_res),
        .m_total_occupancy   (m_total_occupancy),
        .m_last              (m_last),
        .cmd                 (cmd),
        .status              (status)
    );

endmodule
